// ===== rtl/sha1md_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1md_pkg
// shared types and constants for the sha-1 message digest block
// ----------------------------------------------------------------------------
package sha1md_pkg;

   localparam int NUM_WORDS        = 5;
   localparam int BLOCK_WORDS      = 16;
   localparam int COUNT_WIDTH      = 61;
   localparam int ROUNDS_PER_GROUP = 20;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [NUM_WORDS-1:0][31:0] IV_WORDS = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   localparam logic [3:0][31:0] ROUND_K = {
      32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
   };

   // round groups of twenty rounds each
   localparam logic [1:0] GROUP_CH    = 2'd0;
   localparam logic [1:0] GROUP_PAR_A = 2'd1;
   localparam logic [1:0] GROUP_MAJ   = 2'd2;
   localparam logic [1:0] GROUP_PAR_B = 2'd3;

   localparam logic [2:0] LAST_WORD = 3'(NUM_WORDS - 1);

   typedef struct packed {
      logic       absorb;
      logic       pad;
      logic       write_len;
      logic       load;
      logic       round;
      logic [1:0] group;
      logic       fold;
      logic       restart;
      logic [2:0] word_sel;
   } cmd_type;

   typedef struct packed {
      logic block_last;
      logic tail_full;
   } status_type;

endpackage

// ===== rtl/sha1md_if.sv =====
// ----------------------------------------------------------------------------
// sha1md channel interfaces
// request beats carry message bytes, response beats carry digest words
// ----------------------------------------------------------------------------
interface sha1md_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] msg_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, msg_byte, byte_present, end_of_message, input ready);
   modport sink   (input valid, msg_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1md_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic        digest_last;

   modport source (output valid, digest_word, digest_last, input ready);
   modport sink   (input valid, digest_word, digest_last, output ready);
endinterface

// ===== rtl/sha1md_datapath.sv =====
// ----------------------------------------------------------------------------
// sha1md_datapath
// block buffer, byte count, chaining words and the one-round-per-cycle unit
// ----------------------------------------------------------------------------
module sha1md_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             msg_byte,
   input  sha1md_pkg::cmd_type    cmd,
   output sha1md_pkg::status_type status,
   output logic [31:0]            digest_word
);
   import sha1md_pkg::*;

   logic [NUM_WORDS-1:0][31:0]   chain_ff, chain_in;
   logic [NUM_WORDS-1:0][31:0]   work_ff, work_in;
   logic [BLOCK_WORDS-1:0][31:0] blk_ff, blk_in;
   logic [COUNT_WIDTH-1:0]       count_ff, count_in;

   logic [5:0]  pos;
   logic [3:0]  word_idx;
   logic [4:0]  shamt;
   logic [7:0]  byte_val;
   logic [31:0] f_val;
   logic [31:0] tmp;
   logic [31:0] sched_x;

   assign pos      = count_ff[5:0];
   assign word_idx = pos[5:2];
   assign shamt    = {~pos[1:0], 3'b000};
   assign byte_val = cmd.pad ? PAD_BYTE : msg_byte;

   assign status.block_last = (pos == 6'd63);
   assign status.tail_full  = (pos >= 6'd56);

   always_comb begin
      case (cmd.group)
         GROUP_CH:  f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         GROUP_MAJ: f_val = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3]) |
                            (work_ff[2] & work_ff[3]);
         default:   f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
      endcase
   end

   assign tmp = {work_ff[0][26:0], work_ff[0][31:27]} + f_val + work_ff[4] + blk_ff[0] +
                ROUND_K[cmd.group];
   assign sched_x = blk_ff[13] ^ blk_ff[8] ^ blk_ff[2] ^ blk_ff[0];

   always_comb begin
      chain_in = chain_ff;
      work_in  = work_ff;
      blk_in   = blk_ff;
      count_in = count_ff;

      if (cmd.absorb || cmd.pad) begin
         blk_in[word_idx] = (blk_ff[word_idx] & ~(32'hFF << shamt)) |
                            ({24'b0, byte_val} << shamt);
      end
      if (cmd.absorb) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end
      if (cmd.write_len) begin
         blk_in[14] = count_ff[60:29];
         blk_in[15] = {count_ff[28:0], 3'b000};
      end
      if (cmd.load) begin
         work_in = chain_ff;
      end
      if (cmd.round) begin
         work_in[4] = work_ff[3];
         work_in[3] = work_ff[2];
         work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
         work_in[1] = work_ff[0];
         work_in[0] = tmp;
         for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            blk_in[i] = blk_ff[i+1];
         end
         blk_in[BLOCK_WORDS-1] = {sched_x[30:0], sched_x[31]};
      end
      if (cmd.fold) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
         blk_in = '0;
      end
      if (cmd.restart) begin
         chain_in = IV_WORDS;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= IV_WORDS;
         work_ff  <= '0;
         blk_ff   <= '0;
         count_ff <= '0;
      end else begin
         chain_ff <= chain_in;
         work_ff  <= work_in;
         blk_ff   <= blk_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      case (cmd.word_sel)
         3'd0:    digest_word = chain_ff[0];
         3'd1:    digest_word = chain_ff[1];
         3'd2:    digest_word = chain_ff[2];
         3'd3:    digest_word = chain_ff[3];
         3'd4:    digest_word = chain_ff[4];
         default: digest_word = '0;
      endcase
   end

endmodule

// ===== rtl/sha1md_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha1md_ctrl
// sequencer for absorb, padding, length, compression rounds and digest output
// ----------------------------------------------------------------------------
module sha1md_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_byte_present,
   input  logic                   req_end_of_message,
   output logic                   req_ready,
   output logic                   rsp_valid,
   output logic                   rsp_last,
   input  logic                   rsp_ready,
   input  sha1md_pkg::status_type status,
   output sha1md_pkg::cmd_type    cmd
);
   import sha1md_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_PAD   = 7'b0000010,
      ST_LEN   = 7'b0000100,
      ST_LOAD  = 7'b0001000,
      ST_ROUND = 7'b0010000,
      ST_FOLD  = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] rnd_ff, rnd_in;
   logic [1:0] grp_ff, grp_in;
   logic [2:0] word_ff, word_in;
   logic       end_pending_ff, end_pending_in;
   logic       padded_ff, padded_in;
   logic       len_done_ff, len_done_in;

   logic req_beat;
   logic rsp_beat;
   logic last_round;

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = (state_ff == ST_EMIT);
   assign rsp_last   = (word_ff == LAST_WORD);
   assign req_beat   = req_valid && req_ready;
   assign rsp_beat   = rsp_valid && rsp_ready;
   assign last_round = (rnd_ff == 5'(ROUNDS_PER_GROUP - 1)) && (grp_ff == GROUP_PAR_B);

   always_comb begin
      state_in       = state_ff;
      rnd_in         = rnd_ff;
      grp_in         = grp_ff;
      word_in        = word_ff;
      end_pending_in = end_pending_ff;
      padded_in      = padded_ff;
      len_done_in    = len_done_ff;
      cmd            = '0;
      cmd.group      = grp_ff;
      cmd.word_sel   = word_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               cmd.absorb     = req_byte_present;
               end_pending_in = req_end_of_message;
               if (req_byte_present && status.block_last) begin
                  state_in = ST_LOAD;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.pad   = 1'b1;
            padded_in = 1'b1;
            if (!status.tail_full) begin
               cmd.write_len = 1'b1;
               len_done_in   = 1'b1;
            end
            state_in = ST_LOAD;
         end
         ST_LEN: begin
            cmd.write_len = 1'b1;
            len_done_in   = 1'b1;
            state_in      = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            rnd_in   = '0;
            grp_in   = GROUP_CH;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (rnd_ff == 5'(ROUNDS_PER_GROUP - 1)) begin
               rnd_in = '0;
               grp_in = grp_ff + 2'd1;
            end else begin
               rnd_in = rnd_ff + 5'd1;
            end
            if (last_round) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (len_done_ff) begin
               word_in  = '0;
               state_in = ST_EMIT;
            end else if (padded_ff) begin
               state_in = ST_LEN;
            end else if (end_pending_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_beat) begin
               if (rsp_last) begin
                  cmd.restart    = 1'b1;
                  end_pending_in = 1'b0;
                  padded_in      = 1'b0;
                  len_done_in    = 1'b0;
                  word_in        = '0;
                  state_in       = ST_IDLE;
               end else begin
                  word_in = word_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rnd_ff         <= '0;
         grp_ff         <= GROUP_CH;
         word_ff        <= '0;
         end_pending_ff <= 1'b0;
         padded_ff      <= 1'b0;
         len_done_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rnd_ff         <= rnd_in;
         grp_ff         <= grp_in;
         word_ff        <= word_in;
         end_pending_ff <= end_pending_in;
         padded_ff      <= padded_in;
         len_done_ff    <= len_done_in;
      end
   end

   a_last_round_folds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) && last_round |=> (state_ff == ST_FOLD))
      else $error("final round not followed by fold");

   a_len_only_at_end: assert property (@(posedge clock) disable iff (reset)
      cmd.write_len |-> end_pending_ff)
      else $error("length written without end of message");

   a_fold_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOLD) && len_done_ff |=> rsp_valid && (word_ff == '0))
      else $error("digest not presented after final block");

   a_no_beat_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> !req_ready && !rsp_valid)
      else $error("channel active during compression");

endmodule

// ===== rtl/sha1_message_digest.sv =====
// ----------------------------------------------------------------------------
// sha1_message_digest
// sha-1 over a byte stream, five digest words per message
// a byte beat is taken while idle; the 64th byte of a block starts compression
// (load, 80 rounds at one round per cycle in the round unit, fold), and no byte
// is taken until it is done; end of message: pad, then compress the final block;
// a second final block adds length, load, 80 rounds, fold; then 5 beats
// synchronous active-high reset restores the initial vector and clears count
// ----------------------------------------------------------------------------
module sha1_message_digest (
   input logic         clock,
   input logic         reset,
   sha1md_req_if.sink  req,
   sha1md_rsp_if.source rsp
);
   import sha1md_pkg::*;

   cmd_type    cmd;
   status_type status;

   sha1md_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req.valid),
      .req_byte_present   (req.byte_present),
      .req_end_of_message (req.end_of_message),
      .req_ready          (req.ready),
      .rsp_valid          (rsp.valid),
      .rsp_last           (rsp.digest_last),
      .rsp_ready          (rsp.ready),
      .status             (status),
      .cmd                (cmd)
   );

   sha1md_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .msg_byte    (req.msg_byte),
      .cmd         (cmd),
      .status      (status),
      .digest_word (rsp.digest_word)
   );

endmodule

// ===== bench/sha1md_checker.sv =====
// ----------------------------------------------------------------------------
// sha1md_checker
// watches the request and response channels of the sha-1 digest block, keeps
// its own sha-1 state, works out the five digest words of every message on
// its end beat and compares each response beat with the oldest word still due
// ----------------------------------------------------------------------------
module sha1md_checker (
   input  logic  clock,
   input  logic  reset,
   sha1md_req_if req,
   sha1md_rsp_if rsp,
   output int    fault_count,
   output int    words_owed,
   output int    words_checked,
   output int    digests_predicted
);
   timeunit 1ns;
   timeprecision 1ps;

   import sha1md_pkg::*;

   typedef struct {
      logic [31:0] word;
      logic        last;
   } digest_beat_type;

   logic [31:0]            chain_h [NUM_WORDS];
   logic [31:0]            block_w [BLOCK_WORDS];
   logic [COUNT_WIDTH-1:0] bytes_taken;
   digest_beat_type        digest_words_due [$];

   function automatic logic [31:0] rol1(input logic [31:0] x);
      return {x[30:0], x[31]};
   endfunction

   function automatic void restart_message();
      for (int i = 0; i < NUM_WORDS; i++) chain_h[i] = IV_WORDS[i];
      for (int i = 0; i < BLOCK_WORDS; i++) block_w[i] = '0;
      bytes_taken = '0;
   endfunction

   function automatic void compress_block();
      logic [31:0] sched [BLOCK_WORDS];
      logic [31:0] a, b, c, d, e, f, w, sum;
      logic [1:0]  grp;
      sched = block_w;
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (int t = 0; t < 80; t++) begin
         if (t < 16) begin
            w = sched[t];
         end else begin
            w = rol1(sched[(t + 13) % 16] ^ sched[(t + 8) % 16] ^
                     sched[(t + 2) % 16] ^ sched[t % 16]);
            sched[t % 16] = w;
         end
         grp = 2'(t / ROUNDS_PER_GROUP);
         case (grp)
            GROUP_CH:  f = (b & c) | (~b & d);
            GROUP_MAJ: f = (b & c) | (b & d) | (c & d);
            default:   f = b ^ c ^ d;
         endcase
         sum = {a[26:0], a[31:27]} + f + e + w + ROUND_K[grp];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = sum;
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
      chain_h[4] += e;
      for (int i = 0; i < BLOCK_WORDS; i++) block_w[i] = '0;
   endfunction

   function automatic void place_byte(input logic [5:0] pos, input logic [7:0] value);
      block_w[pos[5:2]][8 * (3 - pos[1:0]) +: 8] = value;
   endfunction

   function automatic void take_beat(input logic [7:0] value, input logic present,
                                     input logic finish);
      logic [5:0]  pos;
      logic [63:0] bit_len;
      if (present) begin
         place_byte(bytes_taken[5:0], value);
         bytes_taken = bytes_taken + COUNT_WIDTH'(1);
         if (bytes_taken[5:0] == 6'd0) compress_block();
      end
      if (finish) begin
         pos = bytes_taken[5:0];
         place_byte(pos, PAD_BYTE);
         if (pos >= 6'd56) compress_block();
         bit_len = {bytes_taken, 3'b000};
         block_w[14] = bit_len[63:32];
         block_w[15] = bit_len[31:0];
         compress_block();
         for (int i = 0; i < NUM_WORDS; i++) begin
            digest_words_due.push_back('{word: chain_h[i], last: (i == NUM_WORDS - 1)});
         end
         digests_predicted++;
         restart_message();
      end
   endfunction

   task automatic report_fault(input string what);
      $display("%0t ns  sha1 checker: %s", $realtime, what);
      fault_count++;
   endtask

   task automatic check_word();
      digest_beat_type due;
      if (digest_words_due.size() == 0) begin
         report_fault($sformatf("digest beat %h last=%b with no word due",
                                rsp.digest_word, rsp.digest_last));
         return;
      end
      due = digest_words_due.pop_front();
      words_checked++;
      if (rsp.digest_word !== due.word)
         report_fault($sformatf("digest word %h, predicted %h", rsp.digest_word, due.word));
      if (rsp.digest_last !== due.last)
         report_fault($sformatf("digest last flag %b, predicted %b", rsp.digest_last, due.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_message();
         digest_words_due.delete();
      end else begin
         if (rsp.valid && rsp.ready) check_word();
         if (req.valid && req.ready)
            take_beat(req.msg_byte, req.byte_present, req.end_of_message);
      end
      words_owed = digest_words_due.size();
   end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// byte-stream stimulus for the sha-1 digest block: a few directed messages,
// then random messages with lengths around the block and padding boundaries,
// empty beats mixed in, under several sender and receiver idling patterns
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 440;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int items_sent    = 0;
   int empty_beats   = 0;
   int cycle_count   = 0;

   int fault_count, words_owed, words_checked, digests_predicted;

   sha1md_req_if req ();
   sha1md_rsp_if rsp ();

   sha1_message_digest DUT (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   sha1md_checker digest_check (
      .clock             (clock),
      .reset             (reset),
      .req               (req),
      .rsp               (rsp),
      .fault_count       (fault_count),
      .words_owed        (words_owed),
      .words_checked     (words_checked),
      .digests_predicted (digests_predicted)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timed out after %0d cycles", cycle_count);
         $display("sha1_message_digest: mismatch");
         $finish;
      end
   end

   task automatic send_beat(input logic [7:0] value, input logic present, input logic finish);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid          <= 1'b1;
      req.msg_byte       <= value;
      req.byte_present   <= present;
      req.end_of_message <= finish;
      do @(posedge clock); while (!req.ready);
      if (present || finish) items_sent++;
      else empty_beats++;
   endtask

   task automatic send_message(input int len, input bit end_on_byte);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 8) send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
         send_beat(8'($urandom_range(255)), 1'b1, end_on_byte && (i == len - 1));
      end
      if (!end_on_byte || len == 0) send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   initial begin
      int len;
      int phase_end;
      req.valid          = 1'b0;
      req.msg_byte       = 8'h00;
      req.byte_present   = 1'b0;
      req.end_of_message = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty beat, then the empty message
      send_beat(8'hA5, 1'b0, 1'b0);
      send_beat(8'h00, 1'b0, 1'b1);
      // "abc" with the end flag riding on the last byte
      send_beat(8'h61, 1'b1, 1'b0);
      send_beat(8'h00, 1'b0, 1'b0);
      send_beat(8'h62, 1'b1, 1'b0);
      send_beat(8'h63, 1'b1, 1'b1);
      // single byte message
      send_beat(8'hFF, 1'b1, 1'b1);
      // extremes, closed by an empty end beat
      send_beat(8'h00, 1'b1, 1'b0);
      send_beat(8'hFF, 1'b1, 1'b0);
      send_beat(8'hFF, 1'b0, 1'b0);
      send_beat(8'h5A, 1'b1, 1'b0);
      send_beat(8'hC3, 1'b0, 1'b1);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 52; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 52; end
            default: begin send_idle_pct = 15; stall_pct = 15; end
         endcase
         phase_end = items_sent + RANDOM_ITEMS / 4;
         while (items_sent < phase_end) begin
            if ($urandom_range(99) < 15) begin
               case ($urandom_range(6))
                  0: len = 55;
                  1: len = 56;
                  2: len = 63;
                  3: len = 64;
                  4: len = 65;
                  5: len = 119;
                  default: len = 120;
               endcase
            end else begin
               len = $urandom_range(16);
            end
            send_message(len, 1'($urandom_range(1)));
         end
      end
      req.valid <= 1'b0;

      while (words_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d messages over %0d data and end beats, %0d empty beats interleaved",
               digests_predicted, items_sent, empty_beats);
      $display("%0d digest words compared under four idling patterns", words_checked);
      if (fault_count == 0 && words_owed == 0) begin
         $display("sha1_message_digest: match");
      end else begin
         $display("sha1_message_digest: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/sha1md_pkg.sv
rtl/sha1md_if.sv
rtl/sha1md_datapath.sv
rtl/sha1md_ctrl.sv
rtl/sha1_message_digest.sv
bench/sha1md_checker.sv
bench/tb_top.sv
